/* hw/rtl/circuit_breaker_health_monitor_core_defines.svh */
// Assertion macros shared by the health monitor checker.
`ifndef CIRCUIT_BREAKER_HEALTH_MONITOR_CORE_DEFINES_SVH
`define CIRCUIT_BREAKER_HEALTH_MONITOR_CORE_DEFINES_SVH

// Clocked assertion on clock, disabled while reset is high.
`define CBHM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A stalled signal must hold its value into the next cycle.
`define CBHM_ASSERT_HOLD(label, vld, stl, sig, msg) \
   `CBHM_ASSERT(label, (vld && stl) |=> $stable(sig), msg)

`endif

/* hw/rtl/cbhm_pkg.sv */
// Types, constants and constant-divide helpers for the health monitor.
`default_nettype none

package cbhm_pkg;

   typedef enum logic [1:0] {
      ST_HEALTHY   = 2'd0,
      ST_UNHEALTHY = 2'd1,
      ST_OPEN      = 2'd2
   } health_type;

   typedef enum logic [2:0] {
      OP_PROBE_PASS    = 3'd0,
      OP_PROBE_FAIL    = 3'd1,
      OP_REQUEST_DONE  = 3'd2,
      OP_TICK          = 3'd3,
      OP_METRICS_RESET = 3'd4
   } op_type;

   localparam logic [2:0] CSR_FAIL_THRESHOLD  = 3'd0;
   localparam logic [2:0] CSR_PROBES_NEEDED   = 3'd1;
   localparam logic [2:0] CSR_PROBE_TIMEOUT_S = 3'd2;
   localparam logic [2:0] CSR_ACCEPT_DELAY_S  = 3'd3;
   localparam logic [2:0] CSR_TOTAL_COST      = 3'd4;

   localparam logic [16:0] Q16_ONE  = 17'd65536;
   localparam logic [16:0] ERR_STEP = 17'd6554;
   localparam logic [20:0] LAT_REF  = 21'd1280000;
   localparam logic [15:0] COST_CAP = 16'd20000;

   // Exact floor division by a constant through a rounded-up reciprocal.
   localparam logic [28:0] DIV10_RECIP  = 29'd429496730;
   localparam int          DIV10_SHIFT  = 32;
   localparam logic [21:0] DIV20_RECIP  = 22'd3355444;
   localparam int          DIV20_SHIFT  = 26;
   localparam logic [26:0] DIV625_RECIP = 27'd109951163;
   localparam int          DIV625_SHIFT = 36;

   typedef struct packed {
      logic [7:0]  fail_threshold;
      logic [7:0]  probes_needed;
      logic [15:0] probe_timeout_s;
      logic [15:0] accept_delay_s;
      logic [15:0] total_cost;
   } cfg_type;

   typedef struct packed {
      health_type  health;
      logic [7:0]  fail_run;
      logic [7:0]  probe_passes;
      logic [15:0] open_seconds;
      logic        probe_flag;
      logic [23:0] latency_avg;
      logic [16:0] ok_rate;
      logic [16:0] err_rate;
   } monitor_state_type;

   typedef struct packed {
      monitor_state_type st;
      logic              is_request;
      logic              is_reset;
   } snap_type;

   typedef struct packed {
      health_type  status;
      logic        healthy;
      logic        accepts_requests;
      logic [15:0] retry_delay_s;
      logic        probe_requested;
      logic [7:0]  failure_count;
      logic [23:0] avg_latency;
      logic [16:0] pass_ratio;
      logic [16:0] fault_ratio;
      logic [16:0] perf_value;
      logic [16:0] spend_score;
   } rsp_type;

   localparam cfg_type CFG_RESET = '{
      fail_threshold:  8'd5,
      probes_needed:   8'd3,
      probe_timeout_s: 16'd60,
      accept_delay_s:  16'd300,
      total_cost:      16'd0
   };

   localparam monitor_state_type STATE_RESET = '{
      health:       ST_HEALTHY,
      fail_run:     8'd0,
      probe_passes: 8'd0,
      open_seconds: 16'd0,
      probe_flag:   1'b0,
      latency_avg:  24'd0,
      ok_rate:      Q16_ONE,
      err_rate:     17'd0
   };

   function automatic logic [23:0] div10(input logic [27:0] num);
      logic [56:0] prod;
      prod = 57'(num) * 57'(DIV10_RECIP);
      return 24'(prod >> DIV10_SHIFT);
   endfunction

   function automatic logic [16:0] div20(input logic [20:0] num);
      logic [42:0] prod;
      prod = 43'(num) * 43'(DIV20_RECIP);
      return 17'(prod >> DIV20_SHIFT);
   endfunction

   function automatic logic [16:0] div625(input logic [25:0] num);
      logic [52:0] prod;
      prod = 53'(num) * 53'(DIV625_RECIP);
      return 17'(prod >> DIV625_SHIFT);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/circuit_breaker_health_monitor_core.sv */
// Top level of the circuit breaker health monitor.
// The block tracks one service target and takes one event per clock cycle
// in sustained operation while the result side does not stall; every event
// gives exactly one result, which passes the input, middle and result
// registers in turn on its way to the result ports. The rate is set by the
// breaker and moving-average update, which reads and rewrites the monitor
// state for each event, and the performance and cost scores follow
// in a second stage ahead of the result register. Configuration writes are
// taken in every cycle and must only be made while no transaction is in flight.
`default_nettype none

module circuit_breaker_health_monitor_core import cbhm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_latency_ms,
   input  logic        req_request_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_healthy,
   output logic        rsp_accepts_requests,
   output logic [15:0] rsp_retry_delay_s,
   output logic        rsp_probe_requested,
   output logic [7:0]  rsp_failure_count,
   output logic [23:0] rsp_avg_latency,
   output logic [16:0] rsp_success_rate,
   output logic [16:0] rsp_error_rate,
   output logic [16:0] rsp_performance_score,
   output logic [16:0] rsp_cost_score,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type           cfg_ff;
   monitor_state_type state_ff;
   monitor_state_type state_in;
   logic              in_valid_ff;
   op_type            in_op_ff;
   logic [15:0]       in_lat_ff;
   logic              in_ok_ff;
   logic              mid_valid_ff;
   snap_type          mid_ff;
   snap_type          mid_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic [16:0]       perf_ff;
   logic              out_en;
   logic              mid_en;
   logic              in_en;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign mid_en    = !mid_valid_ff || out_en;
   assign in_en     = !in_valid_ff || mid_en;
   assign req_stall = !in_en;
   assign csr_ready = 1'b1;

   cbhm_breaker u_breaker (
      .op         (in_op_ff),
      .latency_ms (in_lat_ff),
      .request_ok (in_ok_ff),
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .nxt        (state_in)
   );

   always_comb begin
      mid_in.st         = state_in;
      mid_in.is_request = (in_op_ff == OP_REQUEST_DONE);
      mid_in.is_reset   = (in_op_ff == OP_METRICS_RESET);
   end

   cbhm_scores u_scores (
      .snap      (mid_ff),
      .perf_prev (perf_ff),
      .cfg       (cfg_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
         perf_ff      <= Q16_ONE;
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FAIL_THRESHOLD:  cfg_ff.fail_threshold  <= csr_data[7:0];
               CSR_PROBES_NEEDED:   cfg_ff.probes_needed   <= csr_data[7:0];
               CSR_PROBE_TIMEOUT_S: cfg_ff.probe_timeout_s <= csr_data;
               CSR_ACCEPT_DELAY_S:  cfg_ff.accept_delay_s  <= csr_data;
               CSR_TOTAL_COST:      cfg_ff.total_cost      <= csr_data;
               default: begin
               end
            endcase
         end
         if (in_en) begin
            in_valid_ff <= req_valid;
         end
         if (mid_en) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (in_valid_ff && mid_en) begin
            state_ff <= state_in;
         end
         if (out_en) begin
            rsp_valid_ff <= mid_valid_ff;
         end
         if (mid_valid_ff && out_en) begin
            perf_ff <= rsp_in.perf_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_en) begin
         in_op_ff  <= op_type'(req_operation);
         in_lat_ff <= req_latency_ms;
         in_ok_ff  <= req_request_ok;
      end
      if (in_valid_ff && mid_en) begin
         mid_ff <= mid_in;
      end
      if (mid_valid_ff && out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_healthy           = rsp_ff.healthy;
   assign rsp_accepts_requests  = rsp_ff.accepts_requests;
   assign rsp_retry_delay_s     = rsp_ff.retry_delay_s;
   assign rsp_probe_requested   = rsp_ff.probe_requested;
   assign rsp_failure_count     = rsp_ff.failure_count;
   assign rsp_avg_latency       = rsp_ff.avg_latency;
   assign rsp_success_rate      = rsp_ff.pass_ratio;
   assign rsp_error_rate        = rsp_ff.fault_ratio;
   assign rsp_performance_score = rsp_ff.perf_value;
   assign rsp_cost_score        = rsp_ff.spend_score;

endmodule

`default_nettype wire

/* hw/rtl/cbhm_breaker.sv */
// Next-state logic of the breaker and the latency and success averages.
`default_nettype none

module cbhm_breaker import cbhm_pkg::*; (
   input  op_type            op,
   input  logic [15:0]       latency_ms,
   input  logic              request_ok,
   input  cfg_type           cfg,
   input  monitor_state_type cur,
   output monitor_state_type nxt
);

   logic [27:0] lat_num;
   logic [23:0] lat_div;
   logic        rate_ok;
   logic [20:0] rate_num;
   logic [16:0] rate_new;
   logic [7:0]  fail_inc;
   logic [7:0]  pass_inc;
   logic [15:0] open_inc;
   logic [17:0] err_sum;

   always_comb begin
      lat_num  = 28'({latency_ms, 8'd0}) + 28'(cur.latency_avg) * 28'd9 + 28'd5;
      lat_div  = div10(lat_num);
      rate_ok  = (op == OP_PROBE_PASS) ? 1'b1 : request_ok;
      rate_num = 21'(cur.ok_rate) * 21'd19 + 21'd10 + (rate_ok ? 21'(Q16_ONE) : 21'd0);
      rate_new = div20(rate_num);
      fail_inc = (cur.fail_run == 8'hFF) ? 8'hFF : cur.fail_run + 8'd1;
      pass_inc = (cur.probe_passes == 8'hFF) ? 8'hFF : cur.probe_passes + 8'd1;
      open_inc = (cur.open_seconds == 16'hFFFF) ? 16'hFFFF : cur.open_seconds + 16'd1;
      err_sum  = 18'(cur.err_rate) + 18'(ERR_STEP);

      nxt = cur;
      case (op)
         OP_PROBE_PASS: begin
            nxt.fail_run   = 8'd0;
            nxt.probe_flag = 1'b0;
            if (cur.health == ST_OPEN) begin
               nxt.probe_passes = pass_inc;
               if (pass_inc >= cfg.probes_needed) begin
                  nxt.health       = ST_HEALTHY;
                  nxt.probe_passes = 8'd0;
                  nxt.open_seconds = 16'd0;
               end
            end else if (cur.health == ST_UNHEALTHY) begin
               nxt.health = ST_HEALTHY;
            end
            nxt.ok_rate = rate_new;
         end
         OP_PROBE_FAIL: begin
            nxt.probe_flag = 1'b0;
            nxt.err_rate   = (err_sum > 18'(Q16_ONE)) ? Q16_ONE : err_sum[16:0];
            nxt.ok_rate    = (cur.ok_rate > ERR_STEP) ? cur.ok_rate - ERR_STEP : 17'd0;
            if (fail_inc >= cfg.fail_threshold) begin
               nxt.health       = ST_OPEN;
               nxt.open_seconds = 16'd0;
               nxt.probe_passes = 8'd0;
               nxt.fail_run     = cfg.fail_threshold;
            end else begin
               nxt.fail_run = fail_inc;
               if (fail_inc >= 8'd2) begin
                  nxt.health = ST_UNHEALTHY;
               end
            end
         end
         OP_REQUEST_DONE: begin
            nxt.latency_avg = (cur.latency_avg == 24'd0) ? {latency_ms, 8'd0} : lat_div;
            nxt.ok_rate     = rate_new;
         end
         OP_TICK: begin
            if (cur.health == ST_OPEN) begin
               nxt.open_seconds = open_inc;
               if (open_inc >= cfg.probe_timeout_s) begin
                  nxt.probe_flag = 1'b1;
               end
            end
         end
         OP_METRICS_RESET: begin
            nxt = STATE_RESET;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/cbhm_scores.sv */
// Result assembly: retry delay, performance score and cost score.
`default_nettype none

module cbhm_scores import cbhm_pkg::*; (
   input  snap_type    snap,
   input  logic [16:0] perf_prev,
   input  cfg_type     cfg,
   output rsp_type     rsp
);

   logic        is_open;
   logic [15:0] delay_gap;
   logic [20:0] lat_gap;
   logic [25:0] perf_num;
   logic [14:0] cost_gap;
   logic [25:0] cost_num;

   always_comb begin
      is_open   = (snap.st.health == ST_OPEN);
      delay_gap = (cfg.accept_delay_s > snap.st.open_seconds) ?
                  cfg.accept_delay_s - snap.st.open_seconds : 16'd0;
      lat_gap   = (snap.st.latency_avg < 24'(LAT_REF)) ?
                  21'(24'(LAT_REF) - snap.st.latency_avg) : 21'd0;
      perf_num  = 26'(snap.st.ok_rate) * 26'd375 + 26'({lat_gap, 4'd0}) + 26'd312;
      cost_gap  = 15'(COST_CAP - cfg.total_cost);
      cost_num  = 26'({cost_gap, 11'd0}) + 26'd312;

      rsp.status           = snap.st.health;
      rsp.healthy          = (snap.st.health == ST_HEALTHY);
      rsp.accepts_requests = !is_open || (snap.st.open_seconds >= cfg.accept_delay_s);
      rsp.retry_delay_s    = !is_open ? 16'd0 : ((delay_gap == 16'd0) ? 16'd1 : delay_gap);
      rsp.probe_requested  = snap.st.probe_flag;
      rsp.failure_count    = snap.st.fail_run;
      rsp.avg_latency      = snap.st.latency_avg;
      rsp.pass_ratio       = snap.st.ok_rate;
      rsp.fault_ratio      = snap.st.err_rate;
      if (snap.is_request) begin
         rsp.perf_value = div625(perf_num);
      end else if (snap.is_reset) begin
         rsp.perf_value = Q16_ONE;
      end else begin
         rsp.perf_value = perf_prev;
      end
      rsp.spend_score = (cfg.total_cost >= COST_CAP) ? 17'd0 : div625(cost_num);
   end

endmodule

`default_nettype wire

/* hw/rtl/cbhm_checker.sv */
// Port-level assertions for the health monitor and their bind to the top level.
`default_nettype none
`include "circuit_breaker_health_monitor_core_defines.svh"

module cbhm_checker import cbhm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_healthy,
   input logic        rsp_accepts_requests,
   input logic [15:0] rsp_retry_delay_s,
   input logic        rsp_probe_requested,
   input logic [7:0]  rsp_failure_count,
   input logic [23:0] rsp_avg_latency,
   input logic [16:0] rsp_success_rate,
   input logic [16:0] rsp_error_rate,
   input logic [16:0] rsp_performance_score,
   input logic [16:0] rsp_cost_score
);

   logic [120:0] rsp_payload;

   assign rsp_payload = {rsp_status, rsp_healthy, rsp_accepts_requests, rsp_retry_delay_s,
                         rsp_probe_requested, rsp_failure_count, rsp_avg_latency,
                         rsp_success_rate, rsp_error_rate, rsp_performance_score,
                         rsp_cost_score};

   // A stalled result transaction stays offered.
   `CBHM_ASSERT(a_rsp_valid_hold, (rsp_valid && rsp_stall) |=> rsp_valid, "rsp_valid dropped")

   `CBHM_ASSERT_HOLD(a_rsp_payload_hold, rsp_valid, rsp_stall, rsp_payload, "rsp payload changed")

   // With the result side free, an accepted transaction is offered on the result port.
   `CBHM_ASSERT(a_rsp_latency, (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid, "result missing")

   // A closed circuit always accepts requests and asks for no retry delay.
   `CBHM_ASSERT(a_closed_accepts, (rsp_valid && rsp_status != ST_OPEN) |-> (rsp_accepts_requests && rsp_retry_delay_s == 16'd0), "closed circuit refused")

endmodule

bind circuit_breaker_health_monitor_core cbhm_checker u_cbhm_checker (.*);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circuit breaker health monitor core.
module tb;
   import cbhm_pkg::*;

   localparam int CYCLE_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [2:0] OP_SPARE_FIRST = 3'(OP_METRICS_RESET) + 3'd1;

   typedef struct {
      logic [2:0]  code;
      logic [15:0] latency_ms;
      logic        request_ok;
   } monitor_event_type;

   typedef struct {
      logic [1:0]  status;
      logic        healthy;
      logic        accepts;
      logic [15:0] retry;
      logic        probe;
      logic [7:0]  fail_count;
      logic [23:0] avg_latency;
      logic [16:0] ok_rate;
      logic [16:0] err_rate;
      logic [16:0] perf;
      logic [16:0] cost;
   } health_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic [15:0] req_latency_ms = '0;
   logic        req_request_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_healthy;
   logic        rsp_accepts_requests;
   logic [15:0] rsp_retry_delay_s;
   logic        rsp_probe_requested;
   logic [7:0]  rsp_failure_count;
   logic [23:0] rsp_avg_latency;
   logic [16:0] rsp_success_rate;
   logic [16:0] rsp_error_rate;
   logic [16:0] rsp_performance_score;
   logic [16:0] rsp_cost_score;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   monitor_event_type pending_events[$];
   health_report_type expected_reports[$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit req_taken = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;

   logic [7:0]  cfg_fail_threshold;
   logic [7:0]  cfg_probes_needed;
   logic [15:0] cfg_probe_timeout;
   logic [15:0] cfg_accept_delay;
   logic [15:0] cfg_total_cost;

   health_type  mdl_health;
   logic [7:0]  mdl_fail_run;
   logic [7:0]  mdl_probe_passes;
   logic [15:0] mdl_open_s;
   logic        mdl_probe_flag;
   logic [23:0] mdl_lat_avg;
   logic [16:0] mdl_ok_rate;
   logic [16:0] mdl_err_rate;
   logic [16:0] mdl_perf;

   circuit_breaker_health_monitor_core dut (.*);

   always #1 clock = ~clock;

   function automatic void clear_health_state();
      mdl_health = ST_HEALTHY;
      mdl_fail_run = '0;
      mdl_probe_passes = '0;
      mdl_open_s = '0;
      mdl_probe_flag = 1'b0;
      mdl_lat_avg = '0;
      mdl_ok_rate = Q16_ONE;
      mdl_err_rate = '0;
      mdl_perf = Q16_ONE;
   endfunction

   function automatic logic [16:0] blend_ok_rate(logic [16:0] rate, logic ok);
      logic [31:0] v;
      v = (32'(rate) * 32'd19 + 32'd10 + (ok ? 32'(Q16_ONE) : 32'd0)) / 32'd20;
      return (v > 32'(Q16_ONE)) ? Q16_ONE : v[16:0];
   endfunction

   function automatic health_report_type apply_health_event(monitor_event_type ev);
      health_report_type r;
      logic [31:0] wide;
      logic [31:0] lat_gap;
      logic [7:0] run;
      case (ev.code)
         OP_PROBE_PASS: begin
            mdl_fail_run = '0;
            mdl_probe_flag = 1'b0;
            if (mdl_health == ST_OPEN) begin
               if (mdl_probe_passes != 8'hFF) mdl_probe_passes++;
               if (mdl_probe_passes >= cfg_probes_needed) begin
                  mdl_health = ST_HEALTHY;
                  mdl_probe_passes = '0;
                  mdl_open_s = '0;
               end
            end else if (mdl_health == ST_UNHEALTHY) begin
               mdl_health = ST_HEALTHY;
            end
            mdl_ok_rate = blend_ok_rate(mdl_ok_rate, 1'b1);
         end
         OP_PROBE_FAIL: begin
            run = (mdl_fail_run == 8'hFF) ? 8'hFF : mdl_fail_run + 8'd1;
            mdl_probe_flag = 1'b0;
            wide = 32'(mdl_err_rate) + 32'(ERR_STEP);
            mdl_err_rate = (wide > 32'(Q16_ONE)) ? Q16_ONE : wide[16:0];
            mdl_ok_rate = (mdl_ok_rate > ERR_STEP) ? mdl_ok_rate - ERR_STEP : '0;
            if (run >= cfg_fail_threshold) begin
               mdl_health = ST_OPEN;
               mdl_open_s = '0;
               mdl_probe_passes = '0;
               mdl_fail_run = cfg_fail_threshold;
            end else begin
               mdl_fail_run = run;
               if (run >= 8'd2) mdl_health = ST_UNHEALTHY;
            end
         end
         OP_REQUEST_DONE: begin
            wide = 32'(ev.latency_ms) << 8;
            if (mdl_lat_avg != '0)
               wide = (wide + 32'd9 * 32'(mdl_lat_avg) + 32'd5) / 32'd10;
            mdl_lat_avg = (wide > 32'hFF_FFFF) ? 24'hFF_FFFF : wide[23:0];
            mdl_ok_rate = blend_ok_rate(mdl_ok_rate, ev.request_ok);
            lat_gap = (32'(mdl_lat_avg) < 32'(LAT_REF)) ?
                      32'(LAT_REF) - 32'(mdl_lat_avg) : 32'd0;
            mdl_perf = 17'((32'd375 * 32'(mdl_ok_rate) + 32'd16 * lat_gap + 32'd312)
                           / 32'd625);
         end
         OP_TICK: begin
            if (mdl_health == ST_OPEN) begin
               if (mdl_open_s != 16'hFFFF) mdl_open_s++;
               if (mdl_open_s >= cfg_probe_timeout) mdl_probe_flag = 1'b1;
            end
         end
         OP_METRICS_RESET: begin
            clear_health_state();
         end
         default: begin
         end
      endcase
      r.status = mdl_health;
      r.healthy = (mdl_health == ST_HEALTHY);
      r.accepts = (mdl_health != ST_OPEN) || (mdl_open_s >= cfg_accept_delay);
      r.retry = '0;
      if (mdl_health == ST_OPEN)
         r.retry = (17'(cfg_accept_delay) > 17'(mdl_open_s) + 17'd1) ?
                   cfg_accept_delay - mdl_open_s : 16'd1;
      r.probe = mdl_probe_flag;
      r.fail_count = mdl_fail_run;
      r.avg_latency = mdl_lat_avg;
      r.ok_rate = mdl_ok_rate;
      r.err_rate = mdl_err_rate;
      r.perf = mdl_perf;
      r.cost = '0;
      if (cfg_total_cost < COST_CAP)
         r.cost = 17'(((32'(COST_CAP) - 32'(cfg_total_cost)) * 32'd2048 + 32'd312)
                      / 32'd625);
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      health_report_type want;
      health_report_type fresh;
      monitor_event_type seen;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circuit_breaker_health_monitor_core regression: fail");
         $finish;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            seen = '{code: req_operation, latency_ms: req_latency_ms,
                     request_ok: req_request_ok};
            fresh = apply_health_event(seen);
            expected_reports = {expected_reports, fresh};
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: result transaction with no expectation pending", $time);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("rsp_status", 32'(want.status), 32'(rsp_status));
               check_field("rsp_healthy", 32'(want.healthy), 32'(rsp_healthy));
               check_field("rsp_accepts_requests", 32'(want.accepts),
                           32'(rsp_accepts_requests));
               check_field("rsp_retry_delay_s", 32'(want.retry), 32'(rsp_retry_delay_s));
               check_field("rsp_probe_requested", 32'(want.probe),
                           32'(rsp_probe_requested));
               check_field("rsp_failure_count", 32'(want.fail_count),
                           32'(rsp_failure_count));
               check_field("rsp_avg_latency", 32'(want.avg_latency), 32'(rsp_avg_latency));
               check_field("rsp_success_rate", 32'(want.ok_rate), 32'(rsp_success_rate));
               check_field("rsp_error_rate", 32'(want.err_rate), 32'(rsp_error_rate));
               check_field("rsp_performance_score", 32'(want.perf),
                           32'(rsp_performance_score));
               check_field("rsp_cost_score", 32'(want.cost), 32'(rsp_cost_score));
            end
         end
      end
   end

   always @(negedge clock) begin : event_driver
      monitor_event_type ev;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!req_valid || req_taken) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            ev = pending_events.pop_front();
            req_valid <= 1'b1;
            req_operation <= ev.code;
            req_latency_ms <= ev.latency_ms;
            req_request_ok <= ev.request_ok;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic logic [15:0] random_latency();
      case ($urandom_range(3))
         0: return 16'($urandom_range(40));
         1: return 16'($urandom_range(6000));
         2: return 16'($urandom_range(65535));
         default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic push_event(input logic [2:0] code, input logic [15:0] lat, input logic ok);
      monitor_event_type ev;
      ev = '{code: code, latency_ms: lat, request_ok: ok};
      pending_events = {pending_events, ev};
   endtask

   task automatic push_burst(input logic [2:0] code, input int count);
      repeat (count) push_event(code, random_latency(), 1'($urandom_range(1)));
   endtask

   task automatic queue_random_traffic(input int count);
      int added;
      int len;
      added = 0;
      while (added < count) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               len = $urandom_range(1, int'(cfg_fail_threshold) + 1);
               push_burst(OP_PROBE_FAIL, len);
            end
            3, 4: begin
               len = $urandom_range(1, (int'(cfg_accept_delay) + 2 > 40) ?
                                       40 : int'(cfg_accept_delay) + 2);
               push_burst(OP_TICK, len);
            end
            5, 6: begin
               len = $urandom_range(1, int'(cfg_probes_needed) + 1);
               push_burst(OP_PROBE_PASS, len);
            end
            7, 8: begin
               len = $urandom_range(1, 6);
               push_burst(OP_REQUEST_DONE, len);
            end
            default: begin
               len = 1;
               push_event(3'($urandom_range(7)), random_latency(), 1'($urandom_range(1)));
            end
         endcase
         added += len;
      end
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FAIL_THRESHOLD:  cfg_fail_threshold = value[7:0];
         CSR_PROBES_NEEDED:   cfg_probes_needed = value[7:0];
         CSR_PROBE_TIMEOUT_S: cfg_probe_timeout = value;
         CSR_ACCEPT_DELAY_S:  cfg_accept_delay = value;
         CSR_TOTAL_COST:      cfg_total_cost = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_csr(input logic [7:0] threshold, input logic [7:0] probes,
                                input logic [15:0] timeout_s, input logic [15:0] delay_s,
                                input logic [15:0] cost);
      write_csr(CSR_FAIL_THRESHOLD, 16'(threshold));
      write_csr(CSR_PROBES_NEEDED, 16'(probes));
      write_csr(CSR_PROBE_TIMEOUT_S, timeout_s);
      write_csr(CSR_ACCEPT_DELAY_S, delay_s);
      write_csr(CSR_TOTAL_COST, cost);
   endtask

   task automatic wait_for_idle();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg_fail_threshold = CFG_RESET.fail_threshold;
      cfg_probes_needed = CFG_RESET.probes_needed;
      cfg_probe_timeout = CFG_RESET.probe_timeout_s;
      cfg_accept_delay = CFG_RESET.accept_delay_s;
      cfg_total_cost = CFG_RESET.total_cost;
      clear_health_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_all_csr(8'd3, 8'd2, 16'd2, 16'd4, 16'd0);
      send_idle_pct = 26;
      stall_pct = 85;
      push_event(OP_REQUEST_DONE, 16'd0, 1'b1);
      push_event(OP_REQUEST_DONE, 16'd0, 1'b0);
      push_event(OP_REQUEST_DONE, 16'hFFFF, 1'b1);
      push_event(OP_REQUEST_DONE, 16'd0, 1'b1);
      push_burst(OP_TICK, 1);
      push_burst(OP_PROBE_FAIL, 2);
      push_burst(OP_PROBE_PASS, 1);
      push_burst(OP_PROBE_FAIL, 3);
      push_burst(OP_TICK, 5);
      push_burst(OP_PROBE_FAIL, 1);
      push_burst(OP_PROBE_PASS, 2);
      for (int k = 0; k < 3; k++)
         push_event(OP_SPARE_FIRST + 3'(k), random_latency(), 1'($urandom_range(1)));
      push_event(OP_REQUEST_DONE, 16'd1, 1'b0);
      push_burst(OP_METRICS_RESET, 1);
      push_event(OP_REQUEST_DONE, 16'hFFFF, 1'b0);
      queue_random_traffic(380);
      wait_for_idle();

      write_all_csr(8'd0, 8'd0, 16'd0, 16'd0, 16'd20000);
      send_idle_pct = 85;
      stall_pct = 26;
      queue_random_traffic(370);
      wait_for_idle();

      write_all_csr(8'd1, 8'd1, 16'd5, 16'd12, 16'd19999);
      send_idle_pct = 0;
      stall_pct = 0;
      queue_random_traffic(370);
      wait_for_idle();

      write_all_csr(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_burst(OP_PROBE_FAIL, 256);
      push_burst(OP_PROBE_PASS, 255);
      push_burst(OP_PROBE_FAIL, 255);
      push_burst(OP_TICK, 40);
      push_burst(OP_PROBE_PASS, 2);
      push_burst(OP_PROBE_FAIL, 1);
      wait_for_idle();

      if (mismatch_count == 0)
         $display("circuit_breaker_health_monitor_core regression: pass");
      else
         $display("circuit_breaker_health_monitor_core regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cbhm_pkg.sv
hw/rtl/cbhm_breaker.sv
hw/rtl/cbhm_scores.sv
hw/rtl/circuit_breaker_health_monitor_core.sv
hw/rtl/cbhm_checker.sv
dv/tb.sv
